FILE: hdl/ksl_pkg.sv
// ---------------------------------------------------------------------------
// ksl_pkg: shared types and codes for the keyed sequential list
// Operation codes, result status codes, sequencer states and the control
// bundle that the top level sends to every cell of the chain.
// ---------------------------------------------------------------------------
package ksl_pkg;

  localparam int KEY_W  = 64;
  localparam int DL_W   = 16;
  localparam int MODE_W = 2;
  localparam int POS_W  = 6;
  localparam int STAT_W = 3;
  localparam int CNTO_W = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  // Any mode with this bit set is a read.
  localparam int MODE_READ_BIT = 1;

  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_READ_OK   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd5;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } seq_state_t;

  typedef struct packed {
    logic capture;  // sample the compare and read-select results
    logic load;     // write the item's key and deadline into this cell
    logic shift;    // take the contents of the next cell up
  } cell_ctl_t;

endpackage

FILE: hdl/ksl_cell.sv
// ---------------------------------------------------------------------------
// ksl_cell: one position of the list
// Holds one key and deadline, compares its key against the item's key,
// offers its contents when its position is read, and shifts down from its
// upper neighbor when an entry at or below it is removed.
// ---------------------------------------------------------------------------
module ksl_cell
  import ksl_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] cmp_key,
  input  logic [DL_W-1:0]  new_deadline,
  input  logic [POS_W-1:0] position,
  input  logic [KEY_W-1:0] nb_key,
  input  logic [DL_W-1:0]  nb_deadline,
  output logic [KEY_W-1:0] ent_key,
  output logic [DL_W-1:0]  ent_deadline,
  output logic             hit,
  output logic             rd_sel,
  output logic [KEY_W-1:0] rd_key,
  output logic [DL_W-1:0]  rd_deadline
);

  logic occupied;
  logic pos_match;

  assign occupied  = 32'(count) > 32'(INDEX);
  assign pos_match = occupied && ({26'd0, position} == 32'(INDEX));

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit         <= occupied && (ent_key == cmp_key);
      rd_sel      <= pos_match;
      rd_key      <= ent_key & {KEY_W{pos_match}};
      rd_deadline <= ent_deadline & {DL_W{pos_match}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent_key      <= cmp_key;
      ent_deadline <= new_deadline;
    end else if (ctl.shift) begin
      ent_key      <= nb_key;
      ent_deadline <= nb_deadline;
    end
  end

endmodule

FILE: hdl/ksl_prefix.sv
// ---------------------------------------------------------------------------
// ksl_prefix: parallel prefix OR
// Bit i of the result is set when any input bit at or below i is set.
// Built as a log-depth tree so the first-match decision stays shallow.
// ---------------------------------------------------------------------------
module ksl_prefix #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] lvl [LEVELS+1];

  always_comb begin
    lvl[0] = din;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign dout = lvl[LEVELS];

endmodule

FILE: hdl/keyed_sequential_list_core.sv
// ---------------------------------------------------------------------------
// keyed_sequential_list_core: ordered key/deadline list on a chain of cells
// Insert, remove-first-match and read-by-position, one result per item.
// ---------------------------------------------------------------------------
// In the accept cycle every cell compares its key and its position against the
// item at once and registers the outcome; in the busy state a prefix OR over the
// registered matches picks the first hit, on a remove that cell and all cells
// above it shift down together, on an insert the item is loaded into the cell at
// the count, the count is updated and the result is written to the output
// register. A new item is taken while a result still waits in that register;
// the busy state stalls until the register is free. No clearing pass is needed
// after reset: only entries below the count are ever looked at.
module keyed_sequential_list_core
  import ksl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] mode, [65:2] key, [81:66] deadline, [87:82] position
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [9:3] count, [73:10] read_key, [89:74] read_deadline,
  // [95:90] zero
  output logic [95:0] m_axis_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  seq_state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;

  logic [MODE_W-1:0] op_mode;
  logic [KEY_W-1:0]  op_key;
  logic [DL_W-1:0]   op_deadline;

  logic capture, finish;

  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic [DL_W-1:0]  cell_dl  [CAPACITY];
  logic [KEY_W-1:0] cell_rk  [CAPACITY];
  logic [DL_W-1:0]  cell_rd  [CAPACITY];
  logic [CAPACITY-1:0] hits, first_or, rd_sels;

  logic [KEY_W-1:0]  rd_key_any;
  logic [DL_W-1:0]   rd_dl_any;
  logic [STAT_W-1:0] status;
  logic [CNT_W+CNTO_W-1:0] cnt_ext;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [CNTO_W-1:0] out_count;
  logic [KEY_W-1:0]  out_key;
  logic [DL_W-1:0]   out_dl;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_BUSY;
      S_BUSY: if (!out_valid || m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // No item is taken while reset is held.
  always_comb begin
    s_axis_tready = 1'b0;
    finish        = 1'b0;
    unique case (state)
      S_IDLE: s_axis_tready = !rst;
      S_BUSY: finish = !out_valid || m_axis_tready;
      default: ;
    endcase
  end

  assign capture = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      op_mode     <= s_axis_tdata[1:0];
      op_key      <= s_axis_tdata[65:2];
      op_deadline <= s_axis_tdata[81:66];
    end
  end

  // Cell chain. While idle the cells compare against the incoming item;
  // while busy the same key port carries the held key for an insert.
  logic [KEY_W-1:0] cmp_key;
  assign cmp_key = (state == S_IDLE) ? s_axis_tdata[65:2] : op_key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [KEY_W-1:0] nb_key;
    logic [DL_W-1:0]  nb_dl;

    assign ctl.capture = capture;
    assign ctl.load    = finish && (op_mode == MODE_INSERT) && (32'(count) == 32'(i));
    assign ctl.shift   = finish && (op_mode == MODE_REMOVE) && first_or[i];

    if (i == CAPACITY - 1) begin : g_top
      // The top cell falls out of the list when it shifts.
      assign nb_key = cell_key[i];
      assign nb_dl  = cell_dl[i];
    end else begin : g_mid
      assign nb_key = cell_key[i+1];
      assign nb_dl  = cell_dl[i+1];
    end

    ksl_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .count        (count),
      .cmp_key      (cmp_key),
      .new_deadline (op_deadline),
      .position     (s_axis_tdata[87:82]),
      .nb_key       (nb_key),
      .nb_deadline  (nb_dl),
      .ent_key      (cell_key[i]),
      .ent_deadline (cell_dl[i]),
      .hit          (hits[i]),
      .rd_sel       (rd_sels[i]),
      .rd_key       (cell_rk[i]),
      .rd_deadline  (cell_rd[i])
    );
  end

  ksl_prefix #(
    .WIDTH (CAPACITY)
  ) u_prefix (
    .din  (hits),
    .dout (first_or)
  );

  // At most one cell is selected for a read, so the others contribute zero.
  always_comb begin
    rd_key_any = '0;
    rd_dl_any  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_key_any = rd_key_any | cell_rk[i];
      rd_dl_any  = rd_dl_any | cell_rd[i];
    end
  end

  always_comb begin
    count_next = count;
    status     = STAT_EMPTY;
    if (op_mode[MODE_READ_BIT]) begin
      status = (|rd_sels) ? STAT_READ_OK : STAT_EMPTY;
    end else if (op_mode == MODE_INSERT) begin
      if (count == CNT_W'(CAPACITY)) begin
        status = STAT_FULL;
      end else begin
        status     = STAT_INSERTED;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (first_or[CAPACITY-1]) begin
        status     = STAT_REMOVED;
        count_next = count - CNT_W'(1);
      end else begin
        status = STAT_NOT_FOUND;
      end
    end
  end

  assign cnt_ext = {{CNTO_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (finish) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status <= status;
      out_count  <= cnt_ext[CNTO_W-1:0];
      out_key    <= op_mode[MODE_READ_BIT] ? rd_key_any : '0;
      out_dl     <= op_mode[MODE_READ_BIT] ? rd_dl_any : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_dl, out_key, out_count, out_status};

endmodule
